// File: hdl/fpr_pkg.sv
`timescale 1ns / 1ps
// Package for the framed packet receiver: sizes, codes, FSM state type,
// controller/datapath command and status structs. No dependencies.
package fpr_pkg;

    localparam int PACKET_LEN = 19;
    localparam int CNT_W      = $clog2(PACKET_LEN + 1);
    localparam int ADDR_W     = $clog2(PACKET_LEN);
    localparam int FIELD_W    = 5;
    localparam int BYTE_W     = 8;
    localparam int CSUM_W     = 16;
    localparam int IDLE_W     = 16;

    localparam logic [BYTE_W-1:0] START_MARK = 8'h21;  // '!'

    // stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_IDLE_LIMIT = 1'b0;  // register index (paddr[2])
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 16'd500;

    // input kind carried on s_tuser
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } fpr_state_t;

    typedef struct packed {
        logic accept;  // input transfer this cycle
        logic rd_en;   // issue store read at drain index
        logic send;    // output transfer this cycle
    } fpr_cmd_t;

    typedef struct packed {
        logic emit;    // the current input item finishes a frame
        logic last;    // drain index is on the final byte
    } fpr_status_t;

    function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
        logic [CNT_W+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

endpackage

// File: hdl/framed_packet_receiver.sv
`timescale 1ns / 1ps
// Top level of the framed packet receiver: stream ports, APB register,
// controller and datapath. Depends on fpr_pkg, fpr_ctrl, fpr_datapath.
//
//  channel  | direction | handshake            | contents
//  ---------+-----------+----------------------+----------------------------------
//  s_       | in        | s_tvalid / s_tready  | received byte or ms tick
//  m_       | out       | m_tvalid / m_tready  | one stored byte of a finished frame
//  apb      | in        | psel/penable, pready | idle_limit register at offset 0x0
//
// Input stays ready after an item that finishes no frame. An item that
// finishes a frame of L bytes is followed by a drain: each byte is first read
// from the store's registered read port (ST_READ), then presented (ST_SEND)
// until m_tready takes it. No input transfer is taken during the drain.
// Reset is synchronous, active low: frame empty, idle count zero, idle_limit
// 500. The byte store has no reset; only bytes written in the current frame
// are read. m_ stalls hold the current byte and its fields stable.
module framed_packet_receiver (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fpr_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic                           s_tuser,   // [0] func (0 byte, 1 tick)
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fpr_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] frame_byte,
                                                       // [12:8] byte_index,
                                                       // [17:13] frame_length, rest 0
    output logic                           m_tuser,   // [0] frame_good
    output logic                           m_tlast,   // last byte of the frame
    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fpr_pkg::PADDR_W-1:0]    paddr,
    input  logic [fpr_pkg::PDATA_W-1:0]    pwdata,
    output logic [fpr_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import fpr_pkg::*;

    fpr_cmd_t    cmd;
    fpr_status_t status;

    logic [IDLE_W-1:0]  idle_limit_reg, idle_limit_next;
    logic               cfg_wr;
    logic               cfg_hit;
    logic [BYTE_W-1:0]  frame_byte;
    logic [FIELD_W-1:0] byte_index;
    logic [FIELD_W-1:0] frame_length;
    logic               frame_good;
    logic               last_byte;

    // APB: zero wait states; paddr[2] selects the register, low bits ignored.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == REG_IDLE_LIMIT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

    always_comb begin
        idle_limit_next = idle_limit_reg;
        if (cfg_wr) begin
            idle_limit_next = pwdata[IDLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_limit_reg <= IDLE_LIMIT_RST;
        end else begin
            idle_limit_reg <= idle_limit_next;
        end
    end

    assign prdata = cfg_hit ? PDATA_W'(idle_limit_reg) : '0;

    fpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    fpr_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .ev_func     (s_tuser),
        .ev_byte     (s_tdata),
        .idle_limit  (idle_limit_reg),
        .frame_byte  (frame_byte),
        .byte_index  (byte_index),
        .frame_length(frame_length),
        .frame_good  (frame_good),
        .last_byte   (last_byte)
    );

    assign m_tdata = {{(M_TDATA_W - BYTE_W - 2*FIELD_W){1'b0}},
                      frame_length, byte_index, frame_byte};
    assign m_tuser = frame_good;
    assign m_tlast = last_byte;

    // Input is never taken while a frame byte is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while draining");

    // The last byte's transfer returns the block to accepting input.
    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("no return to input after last byte");

    // A drained frame always has a nonzero length.
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:13] != 5'd0))
        else $error("zero frame length on output");

    // The good flag does not change within one frame's drain.
    a_good_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> ##1 (m_tvalid && $stable(m_tuser)))
        else $error("good flag changed mid-frame");

endmodule

// File: hdl/fpr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/fpr_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: accepts input items, then walks the frame drain.
// Depends on fpr_pkg.
module fpr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  fpr_pkg::fpr_status_t status,
    output fpr_pkg::fpr_cmd_t    cmd
);
    import fpr_pkg::*;

    fpr_state_t state_reg;
    fpr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && status.emit) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    state_next = status.last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.accept = 1'b0;
        cmd.rd_en  = 1'b0;
        cmd.send   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                cmd.send = m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/fpr_datapath.sv
`timescale 1ns / 1ps
// Datapath: byte store, fill and idle counters, running checksum, drain index.
// Depends on fpr_pkg and fpr_ram.
module fpr_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fpr_pkg::fpr_cmd_t            cmd,
    output fpr_pkg::fpr_status_t         status,
    input  logic                         ev_func,
    input  logic [fpr_pkg::BYTE_W-1:0]   ev_byte,
    input  logic [fpr_pkg::IDLE_W-1:0]   idle_limit,
    output logic [fpr_pkg::BYTE_W-1:0]   frame_byte,
    output logic [fpr_pkg::FIELD_W-1:0]  byte_index,
    output logic [fpr_pkg::FIELD_W-1:0]  frame_length,
    output logic                         frame_good,
    output logic                         last_byte
);
    import fpr_pkg::*;

    logic [CNT_W-1:0]  fill_reg,   fill_next;
    logic [IDLE_W-1:0] idle_reg,   idle_next;
    logic [CSUM_W-1:0] sum_reg,    sum_next;
    logic [BYTE_W-1:0] prev1_reg,  prev1_next;
    logic [BYTE_W-1:0] prev2_reg,  prev2_next;
    logic              mark_reg,   mark_next;
    logic [CNT_W-1:0]  len_reg,    len_next;
    logic              good_reg,   good_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;

    logic              is_tick;
    logic              is_mark;
    logic [CNT_W-1:0]  fill_base;
    logic [CNT_W-1:0]  fill_inc;
    logic              byte_emit;
    logic [IDLE_W-1:0] idle_inc;
    logic              tick_due;
    logic              tick_emit;
    logic [CSUM_W-1:0] byte_sum;
    logic [BYTE_W-1:0] byte_p1, byte_p2;
    logic              byte_mark;
    logic [CNT_W-1:0]  f_len;
    logic [CSUM_W-1:0] f_sum;
    logic [BYTE_W-1:0] f_p1, f_p2;
    logic              f_mark;
    logic              good_calc;
    logic [CNT_W-1:0]  rd_idx_ext;
    logic              store_we;

    assign is_tick   = (ev_func == FUNC_TICK);
    assign is_mark   = (ev_byte == START_MARK);
    assign fill_base = is_mark ? '0 : fill_reg;
    assign fill_inc  = fill_base + CNT_W'(1);
    assign byte_emit = (fill_inc == CNT_W'(PACKET_LEN));

    assign idle_inc  = (idle_reg == {IDLE_W{1'b1}}) ? idle_reg : idle_reg + IDLE_W'(1);
    assign tick_due  = (idle_inc >= idle_limit);
    assign tick_emit = tick_due && (fill_reg != '0);

    // Running checksum excludes the two most recent bytes, kept in prev1/prev2.
    always_comb begin
        byte_p1   = ev_byte;
        byte_p2   = prev1_reg;
        byte_sum  = sum_reg;
        byte_mark = mark_reg;
        priority if (fill_base == '0) begin
            byte_sum  = '0;
            byte_mark = is_mark;
            byte_p2   = prev2_reg;
        end else if (fill_base == CNT_W'(1)) begin
            byte_sum = '0;
        end else begin
            byte_sum = sum_reg + CSUM_W'(prev2_reg);
        end
    end

    assign f_len  = is_tick ? fill_reg  : fill_inc;
    assign f_sum  = is_tick ? sum_reg   : byte_sum;
    assign f_p1   = is_tick ? prev1_reg : byte_p1;
    assign f_p2   = is_tick ? prev2_reg : byte_p2;
    assign f_mark = is_tick ? mark_reg  : byte_mark;

    assign good_calc = (f_len >= CNT_W'(2)) && f_mark && ((~f_sum) == {f_p2, f_p1});

    assign status.emit = is_tick ? tick_emit : byte_emit;

    always_comb begin
        fill_next   = fill_reg;
        idle_next   = idle_reg;
        sum_next    = sum_reg;
        prev1_next  = prev1_reg;
        prev2_next  = prev2_reg;
        mark_next   = mark_reg;
        len_next    = len_reg;
        good_next   = good_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.accept) begin
            if (is_tick) begin
                idle_next = tick_due ? '0 : idle_inc;
                fill_next = tick_emit ? '0 : fill_reg;
            end else begin
                idle_next  = '0;
                fill_next  = byte_emit ? '0 : fill_inc;
                sum_next   = byte_sum;
                prev1_next = byte_p1;
                prev2_next = byte_p2;
                mark_next  = byte_mark;
            end
            if (status.emit) begin
                len_next    = f_len;
                good_next   = good_calc;
                rd_idx_next = '0;
            end
        end
        if (cmd.send) begin
            rd_idx_next = rd_idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            idle_reg <= '0;
        end else begin
            fill_reg <= fill_next;
            idle_reg <= idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        prev1_reg  <= prev1_next;
        prev2_reg  <= prev2_next;
        mark_reg   <= mark_next;
        len_reg    <= len_next;
        good_reg   <= good_next;
        rd_idx_reg <= rd_idx_next;
    end

    assign store_we = cmd.accept && !is_tick;

    fpr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(PACKET_LEN)
    ) u_store (
        .aclk (aclk),
        .we   (store_we),
        .waddr(fill_base[ADDR_W-1:0]),
        .wdata(ev_byte),
        .re   (cmd.rd_en),
        .raddr(rd_idx_reg),
        .rdata(frame_byte)
    );

    assign rd_idx_ext   = CNT_W'(rd_idx_reg);
    assign status.last  = ((rd_idx_ext + CNT_W'(1)) == len_reg);
    assign byte_index   = to_field(rd_idx_ext);
    assign frame_length = to_field(len_reg);
    assign frame_good   = good_reg;
    assign last_byte    = status.last;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for framed_packet_receiver: stream and APB stimulus, a
// frame predictor and an in-order result checker. Depends on fpr_pkg and the RTL.
module tb;
    import fpr_pkg::*;

    // Generous cycle ceiling for the whole run.
    localparam int MAX_CYCLES    = 200000;
    // Cycles to let pass before a register write, so that a transfer still in
    // flight has finished.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 50;
    localparam int MAX_REPORTS   = 50;
    localparam logic [PADDR_W-1:0] ADDR_IDLE_LIMIT = {REG_IDLE_LIMIT, 2'b00};

    // One expected output transfer: a stored byte of a finished frame.
    typedef struct {
        logic [7:0]         data;
        logic [FIELD_W-1:0] idx;
        logic [FIELD_W-1:0] len;
        logic               good;
        logic               last;
    } frame_byte_t;

    // Receiver back-pressure styles.
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SLOW
    } rdy_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [7:0] rx_byte
    logic                 s_tuser  = FUNC_BYTE;  // [0] func
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // [7:0] frame_byte, [12:8] byte_index,
                                     // [17:13] frame_length, rest 0
    logic                 m_tuser;   // [0] frame_good
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    framed_packet_receiver DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame predictor: shadow copy of the receiver's store, fill level,
    // idle tick count and idle_limit register.
    // ------------------------------------------------------------------
    logic [7:0]  shadow_store [PACKET_LEN];
    int          shadow_fill  = 0;
    int          shadow_ticks = 0;
    logic [15:0] shadow_limit = IDLE_LIMIT_RST;

    frame_byte_t pending_bytes [$];   // expected transfers, oldest first
    int          err_count   = 0;
    int          item_count  = 0;
    int          cycle_count = 0;

    // Start marker present and inverted 16-bit sum of all but the last two
    // bytes equal to those two bytes, big-endian. Short frames never pass.
    function automatic logic checksum_matches(input int len);
        logic [15:0] acc;
        acc = '0;
        if (len < 2 || shadow_store[0] != START_MARK)
            return 1'b0;
        for (int i = 0; i + 2 < len; i++)
            acc += shadow_store[i];
        return (~acc) == {shadow_store[len-2], shadow_store[len-1]};
    endfunction

    // Queue one transfer per stored byte and empty the frame.
    task automatic flush_frame();
        frame_byte_t fb;
        logic        good;
        good = checksum_matches(shadow_fill);
        for (int k = 0; k < shadow_fill; k++) begin
            fb.data = shadow_store[k];
            fb.idx  = k[FIELD_W-1:0];
            fb.len  = shadow_fill[FIELD_W-1:0];
            fb.good = good;
            fb.last = (k + 1 == shadow_fill);
            pending_bytes.push_back(fb);
        end
        shadow_fill  = 0;
        shadow_ticks = 0;
    endtask

    task automatic predict_item(input logic func, input logic [7:0] b);
        if (func == FUNC_BYTE) begin
            if (b == START_MARK)
                shadow_fill = 0;
            if (shadow_fill < PACKET_LEN) begin
                shadow_store[shadow_fill] = b;
                shadow_fill++;
            end
            shadow_ticks = 0;
            if (shadow_fill >= PACKET_LEN)
                flush_frame();
        end else begin
            if (shadow_ticks < 16'hFFFF)
                shadow_ticks++;
            if (shadow_ticks >= shadow_limit) begin
                // empty frame: count just restarts
                if (shadow_fill == 0)
                    shadow_ticks = 0;
                else
                    flush_frame();
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every m_ transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        frame_byte_t got;
        frame_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.data = m_tdata[7:0];
            got.idx  = m_tdata[12:8];
            got.len  = m_tdata[17:13];
            got.good = m_tuser;
            got.last = m_tlast;
            if (m_tdata[M_TDATA_W-1:18] !== '0)
                report_mismatch($sformatf("tdata pad bits not zero: %h", m_tdata));
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer data %h idx %0d len %0d",
                                          got.data, got.idx, got.len));
            end else begin
                want = pending_bytes.pop_front();
                if (got.data !== want.data || got.idx !== want.idx ||
                    got.len !== want.len || got.good !== want.good ||
                    got.last !== want.last)
                    report_mismatch($sformatf(
                        {"got data %h idx %0d len %0d good %b last %b, ",
                         "want data %h idx %0d len %0d good %b last %b"},
                        got.data, got.idx, got.len, got.good, got.last,
                        want.data, want.idx, want.len, want.good, want.last));
            end
        end
    end

    // Receiver back-pressure: segments of random length, each with its own
    // style, so stalls land on every byte of the drain.
    rdy_mode_t rdy_mode = RDY_ALWAYS;
    int        rdy_left = 0;

    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = rdy_mode_t'($urandom_range(0, 2));
            rdy_left = $urandom_range(10, 60);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == MAX_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of transfers with random gaps. tvalid stays high
    // across a burst; drv_active tracks it so tvalid gets one update per edge.
    // ------------------------------------------------------------------
    logic drv_active = 1'b0;
    int   burst_left = 0;

    task automatic pause_sender();
        if (drv_active) begin
            s_tvalid   <= 1'b0;
            drv_active  = 1'b0;
        end
    endtask

    task automatic send_item(input logic func, input logic [7:0] b);
        int gap;
        s_tvalid   <= 1'b1;
        s_tuser    <= func;
        s_tdata    <= b;
        drv_active  = 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_item(func, b);
        item_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                pause_sender();
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(FUNC_BYTE, b);
    endtask

    // rx_byte is don't-care on a tick; drive it random anyway
    task automatic send_tick();
        send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Hold off until every expected transfer has come back. At least one
    // edge passes, so the next tvalid update lands in a later step.
    task automatic wait_drained();
        pause_sender();
        do
            @(posedge aclk);
        while (pending_bytes.size() != 0);
    endtask

    // Ticks that close a partial frame under the current idle_limit.
    task automatic close_by_idle();
        repeat ((shadow_limit == 0) ? 1 : shadow_limit) send_tick();
    endtask

    // APB write of idle_limit while the receiver is quiet, then read back.
    task automatic set_idle_limit(input logic [15:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_IDLE_LIMIT;
        pwdata  <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        shadow_limit = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {16'h0, shadow_limit})
            report_mismatch($sformatf("idle_limit read %h, want %h", prdata, shadow_limit));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // '!' + body + checksum. Body is random (never '!') or an alternating
    // 0xFF/0x00 pattern; corrupt flips one bit after the marker. A short
    // frame is closed by idle ticks; a few ticks may fall between bytes.
    task automatic send_frame(input int len, input bit corrupt, input bit pattern);
        logic [7:0]  pkt [PACKET_LEN];
        logic [15:0] acc;
        int          pos;
        int          n_ticks;
        pkt[0] = START_MARK;
        acc    = START_MARK;
        for (int i = 1; i + 2 < len; i++) begin
            if (pattern)
                pkt[i] = i[0] ? 8'hFF : 8'h00;
            else
                do pkt[i] = 8'($urandom_range(0, 255)); while (pkt[i] == START_MARK);
            acc += pkt[i];
        end
        acc = ~acc;
        pkt[len-2] = acc[15:8];
        pkt[len-1] = acc[7:0];
        if (corrupt) begin
            pos = $urandom_range(1, len - 1);
            pkt[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < len; i++) begin
            send_byte(pkt[i]);
            if (i < len - 1 && shadow_limit > 1 && $urandom_range(0, 3) == 0) begin
                n_ticks = $urandom_range(1, (shadow_limit > 3) ? 3 : shadow_limit - 1);
                repeat (n_ticks) send_tick();
            end
        end
        if (len < PACKET_LEN)
            close_by_idle();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_reset();
        logic [31:0] rd;
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_IDLE_LIMIT;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        if (rd !== {16'h0, IDLE_LIMIT_RST})
            report_mismatch($sformatf("idle_limit after reset %h", rd));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Good frame that ends by filling the store, bytes at both extremes.
    task automatic test_full_frame();
        send_frame(PACKET_LEN, 1'b0, 1'b1);
    endtask

    // Ticks well below the reset idle_limit of 500 leave a short frame
    // open; more bytes then fill it and end it.
    task automatic test_reset_limit_hold();
        send_byte(START_MARK);
        send_byte(8'hFF);
        send_byte(8'hDE);
        repeat (20) send_tick();
        repeat (PACKET_LEN - 3) send_byte(8'h5A);
    endtask

    // idle_limit 0: every tick ends a non-empty frame.
    task automatic test_zero_limit();
        set_idle_limit(16'd0);
        send_tick();                         // empty frame: count restarts only
        send_byte(START_MARK);               // one byte: never good
        send_tick();
        send_byte(START_MARK);               // two bytes: all checksum, bad
        send_byte(8'h00);
        send_tick();
        send_byte(START_MARK);               // shortest good frame
        send_byte(8'hFF);
        send_byte(8'hDE);
        send_tick();
        send_byte(8'h41);                    // no start marker
        send_byte(8'h42);
        send_tick();
        send_byte(START_MARK);               // marker mid-frame restarts it
        send_byte(8'h00);
        send_byte(START_MARK);
        send_byte(8'hFF);
        send_byte(8'hDE);
        send_tick();
    endtask

    // Mostly well-formed frames with random content, some corrupted, plus
    // noise, broken frames and an occasional full drain.
    task automatic test_random_traffic(input logic [15:0] limit, input int n_items);
        int stop_at;
        int pick;
        int len;
        set_idle_limit(limit);
        stop_at = item_count + n_items;
        while (item_count < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                if (limit == 16'hFFFF || $urandom_range(0, 3) == 0)
                    len = PACKET_LEN;
                else
                    len = $urandom_range(3, 10);
                send_frame(len, pick == 5, 1'b0);
            end else if (pick < 8) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 2) == 0)
                        send_tick();
                    else
                        send_byte(($urandom_range(0, 7) == 0) ? START_MARK
                                                              : 8'($urandom_range(0, 255)));
                end
            end else if (pick == 8) begin
                // broken frame: marker, a few bytes, cut short
                send_byte(START_MARK);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
                if (limit != 16'hFFFF)
                    close_by_idle();
            end else begin
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_reset();
        test_full_frame();
        test_reset_limit_hold();
        test_zero_limit();
        test_random_traffic(16'd1, 90);
        test_random_traffic(16'hFFFF, 90);
        test_random_traffic(16'($urandom_range(2, 16)), 90);
        test_random_traffic(16'd3, 90);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0 && pending_bytes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
hdl/fpr_pkg.sv
hdl/fpr_ram.sv
hdl/fpr_ctrl.sv
hdl/fpr_datapath.sv
hdl/framed_packet_receiver.sv
tb/tb.sv
